// File: hdl/mwpo_pkg.sv
package mwpo_pkg;

  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned MAX_SAMPLE_BITS     = 24;
  localparam int unsigned TUNING_BITS         = 32;
  localparam int unsigned ADDR_BITS           = 3;
  localparam int unsigned DATA_BITS           = 32;

  localparam logic REG_WAVE_MODE   = 1'b0;
  localparam logic REG_TUNING_WORD = 1'b1;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_mode_t;

  // Product of two unsigned Q2.62 values, kept in Q2.62.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Divides a Taylor term by (2n)(2n+1).
  function automatic logic [63:0] taylor_div(input logic [63:0] term, input int unsigned n);
    logic [63:0] q;
    case (n)
      1:       q = term / 64'd6;
      2:       q = term / 64'd20;
      3:       q = term / 64'd42;
      4:       q = term / 64'd72;
      5:       q = term / 64'd110;
      6:       q = term / 64'd156;
      7:       q = term / 64'd210;
      8:       q = term / 64'd272;
      9:       q = term / 64'd342;
      10:      q = term / 64'd420;
      11:      q = term / 64'd506;
      12:      q = term / 64'd600;
      default: q = 64'd0;
    endcase
    return q;
  endfunction

  // One entry of the quarter-wave sine table, evaluated at elaboration.
  function automatic logic [MAX_SAMPLE_BITS-1:0] sine_entry(input int unsigned k,
                                                             input int unsigned table_bits,
                                                             input int unsigned sample_bits);
    logic [63:0] step_hi;
    logic [63:0] step_lo;
    logic [63:0] kk;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] fs_max;
    int unsigned shift;
    kk      = 64'(k);
    step_hi = HALF_PI_Q62 >> table_bits;
    step_lo = HALF_PI_Q62 & ((64'd1 << table_bits) - 64'd1);
    x       = step_hi * kk + ((step_lo * kk) >> table_bits);
    x2      = mul_q62(x, x);
    term    = x;
    sum     = x;
    for (int unsigned n = 1; n <= 12; n++) begin
      term = taylor_div(mul_q62(term, x2), n);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    shift  = 63 - sample_bits;
    v      = (sum + (64'd1 << (shift - 1))) >> shift;
    fs_max = (64'd1 << (sample_bits - 1)) - 64'd1;
    if (v > fs_max) begin
      v = fs_max;
    end
    return v[MAX_SAMPLE_BITS-1:0];
  endfunction

endpackage

// File: hdl/multi_waveform_phase_oscillator.sv
// The sine table read is the first of two pipeline registers; the output register is last.
// Throughput: one tick per cycle while the sample side does not stall.
// The output register and the table stage hold their data while the sample side stalls.
// Synchronous active-high reset clears the phase accumulator, wave_mode, tuning_word
// and both pipeline valid flags. The sine table is constant and needs no clearing.
module multi_waveform_phase_oscillator #(
  parameter int unsigned PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mwpo_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [mwpo_pkg::DATA_BITS-1:0]      pwdata,
  output logic [mwpo_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready,
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  logic                                last_in_block,
  output logic                                sample_valid,
  input  logic                                sample_ready,
  output logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                last
);
  import mwpo_pkg::*;

  localparam int unsigned PB        = PHASE_BITS;
  localparam int unsigned TB        = SINE_TABLE_BITS;
  localparam int unsigned SB        = SAMPLE_BITS;
  localparam int unsigned ROM_DEPTH = (1 << TB) + 1;
  localparam int unsigned STEP_BITS = (PB < TUNING_BITS) ? PB : TUNING_BITS;

  localparam logic [SB-1:0] FS       = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] POS_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic [PB-1:0] HALF     = {1'b1, {(PB-1){1'b0}}};
  localparam logic [TB:0]   TOP_IDX  = {1'b1, {TB{1'b0}}};

  wave_mode_t                 wave_mode;
  logic [TUNING_BITS-1:0]     tuning_word;
  logic [PB-1:0]              phase_acc;

  logic                       s1_valid;
  logic                       s1_ready;
  logic                       s1_load;
  logic                       s2_ready;
  logic [SB-2:0]              rom_q;
  logic                       s1_neg;
  logic                       s1_sine;
  logic [SB-1:0]              s1_other;
  logic                       s1_last;

  logic [SB-2:0]              rom_tbl [ROM_DEPTH];
  logic [TB:0]                rom_idx;
  logic [TB-1:0]              quarter_idx;
  logic [1:0]                 quadrant;
  logic [SB-1:0]              u;
  logic [SB-1:0]              tri_mag;
  logic [SB-1:0]              other_next;
  logic [SB-1:0]              sine_ext;
  logic [SB-1:0]              sample_next;

  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    localparam logic [MAX_SAMPLE_BITS-1:0] ENTRY = sine_entry(k, TB, SB);
    assign rom_tbl[k] = ENTRY[SB-2:0];
  end

  if (PB >= SB) begin : g_u_shift_down
    assign u = phase_acc[PB-1 -: SB];
  end else begin : g_u_shift_up
    assign u = {phase_acc, {(SB-PB){1'b0}}};
  end

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_WAVE_MODE:   prdata = {{(DATA_BITS-2){1'b0}}, wave_mode};
      REG_TUNING_WORD: prdata = tuning_word;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode   <= WAVE_SINE;
      tuning_word <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_WAVE_MODE:   wave_mode   <= wave_mode_t'(pwdata[1:0]);
        REG_TUNING_WORD: tuning_word <= pwdata;
        default:         ;
      endcase
    end
  end

  assign s2_ready   = !sample_valid || sample_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign tick_ready = s1_ready;
  assign s1_load    = tick_valid && tick_ready;

  assign quadrant    = phase_acc[PB-1 -: 2];
  assign quarter_idx = phase_acc[PB-3 -: TB];
  assign rom_idx     = quadrant[0] ? (TOP_IDX - {1'b0, quarter_idx}) : {1'b0, quarter_idx};
  assign tri_mag     = u[SB-1] ? (u - FS) : (FS - u);

  always_comb begin
    case (wave_mode)
      WAVE_SINE:     other_next = '0;
      WAVE_SAW:      other_next = (u == '0) ? POS_MAX : (FS - u);
      WAVE_SQUARE:   other_next = (phase_acc <= HALF) ? POS_MAX : FS;
      WAVE_TRIANGLE: other_next = (u == '0) ? POS_MAX : ({tri_mag[SB-2:0], 1'b0} - FS);
      default:       other_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= tick_valid;
      end
      if (s1_load) begin
        phase_acc <= phase_acc + PB'(tuning_word[STEP_BITS-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      rom_q    <= rom_tbl[rom_idx];
      s1_neg   <= quadrant[1];
      s1_sine  <= (wave_mode == WAVE_SINE);
      s1_other <= other_next;
      s1_last  <= last_in_block;
    end
  end

  assign sine_ext    = s1_neg ? (FS - FS - {1'b0, rom_q}) : {1'b0, rom_q};
  assign sample_next = s1_sine ? sine_ext : s1_other;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (s2_ready) begin
      sample_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      sample <= $signed(sample_next);
      last   <= s1_last;
    end
  end

endmodule

// File: hdl/mwpo_checker.sv
module mwpo_checker #(
  parameter int unsigned SAMPLE_BITS = mwpo_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          pready,
  input logic                          tick_valid,
  input logic                          tick_ready,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          last
);
  import mwpo_pkg::*;

  a_reset_empties: assert property (@(posedge clk) rst |=> !sample_valid)
    else $error("Sample valid after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid && $stable(sample) && $stable(last))
    else $error("Stalled sample changed or dropped.");

  a_sample_has_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(tick_valid && tick_ready, 2))
    else $error("Sample appeared without a tick transfer two cycles earlier.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !sample_valid && pready |-> tick_ready)
    else $error("Tick not taken while the output is empty.");

endmodule

bind multi_waveform_phase_oscillator mwpo_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mwpo_checker (.*);
